/* rtl/http2_frame_header_parser_defines.svh */
// Assertion helpers for the HTTP/2 frame header parser.
// Each macro samples on clk and is off while rst_n is low.
`ifndef HTTP2_FRAME_HEADER_PARSER_DEFINES_SVH
`define HTTP2_FRAME_HEADER_PARSER_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define H2FP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle
`define H2FP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/h2fp_pkg.sv */
package h2fp_pkg;

    // Stream framing constants
    localparam int unsigned PREFACE_LEN = 24;
    localparam int unsigned HEADER_LEN  = 9;
    localparam int unsigned LEN_W       = 24;
    localparam int unsigned STREAM_W    = 31;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 24'd262135;

    // Frame types and flag bits
    localparam logic [7:0] TYPE_DATA       = 8'h00;
    localparam logic [7:0] TYPE_HEADERS    = 8'h01;
    localparam logic [7:0] TYPE_LAST_KNOWN = 8'h09;
    localparam int unsigned FLAG_BIT_STREAM_END  = 0;
    localparam int unsigned FLAG_BIT_HEADERS_END = 2;
    localparam int unsigned FLAG_BIT_PADDED      = 3;
    localparam logic [6:0] STREAM_TOP_MASK = 7'h7f;

    // Result event codes
    localparam logic [1:0] EV_FRAME_DONE   = 2'd0;
    localparam logic [1:0] EV_PREFACE_OK   = 2'd1;
    localparam logic [1:0] EV_PREFACE_BAD  = 2'd2;
    localparam logic [1:0] EV_TOO_LARGE    = 2'd3;

    // Register indexes
    localparam logic REG_EXPECT_PREFACE = 1'b0;
    localparam logic REG_MAX_PAYLOAD    = 1'b1;

    // Client connection preface
    localparam logic [7:0] PREFACE_TEXT [PREFACE_LEN] = '{
        8'h50, 8'h52, 8'h49, 8'h20, 8'h2a, 8'h20, 8'h48, 8'h54,
        8'h54, 8'h50, 8'h2f, 8'h32, 8'h2e, 8'h30, 8'h0d, 8'h0a,
        8'h0d, 8'h0a, 8'h53, 8'h4d, 8'h0d, 8'h0a, 8'h0d, 8'h0a
    };

    typedef enum logic [1:0] {
        PH_PREFACE,
        PH_HEADER,
        PH_PAYLOAD,
        PH_DEAD
    } phase_t;

    typedef struct packed {
        logic [1:0]          event_res;
        logic [7:0]          frame_type;
        logic                known_type;
        logic [7:0]          frame_flags;
        logic [STREAM_W-1:0] stream_number;
        logic [LEN_W-1:0]    payload_len;
        logic [LEN_W-1:0]    body_len;
        logic                stream_end;
        logic                headers_end;
    } result_t;

endpackage

/* rtl/h2fp_if.sv */
// Byte request channel
interface h2fp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// Event result channel
interface h2fp_evt_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      event_res;
    logic [7:0]                      frame_type;
    logic                            known_type;
    logic [7:0]                      frame_flags;
    logic [h2fp_pkg::STREAM_W-1:0]   stream_number;
    logic [h2fp_pkg::LEN_W-1:0]      payload_len;
    logic [h2fp_pkg::LEN_W-1:0]      body_len;
    logic                            stream_end;
    logic                            headers_end;

    modport source (output valid, output event_res, output frame_type, output known_type,
                    output frame_flags, output stream_number, output payload_len,
                    output body_len, output stream_end, output headers_end, input ready);
    modport sink   (input valid, input event_res, input frame_type, input known_type,
                    input frame_flags, input stream_number, input payload_len,
                    input body_len, input stream_end, input headers_end, output ready);
endinterface

/* rtl/http2_frame_header_parser.sv */
// HTTP/2 frame header parser.
// byte_in carries one byte of a connection stream per request (valid/ready).
// evt_out carries one event per completed unit: preface ok or mismatch at the
// 24th preface byte, frame complete at the last payload byte (or at the 9th
// header byte for an empty payload), frame too large at the 9th header byte.
// Latency: the event is presented the cycle after the byte that causes it.
// Throughput: one byte per cycle; all parsing is a single compare/subtract
// pass from the state registers into the event register.
// When evt_out stalls with an event pending, byte_in.ready drops until that
// event is taken; otherwise bytes keep flowing, one per cycle.
// APB registers: 0x0 expect_preface (bit 0), 0x4 max_payload_length (24 bits).
// expect_preface only selects the start phase before the first byte.
// Reset: expect_preface = 1, max_payload_length = 262135, preface phase,
// no event pending. Any error parks the parser, which then drops every byte
// until the next reset.
`include "http2_frame_header_parser_defines.svh"

module http2_frame_header_parser (
    input  logic                clk,
    input  logic                rst_n,
    h2fp_byte_if.sink           byte_in,
    h2fp_evt_if.source          evt_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int unsigned LEN_W = h2fp_pkg::LEN_W;
    localparam int unsigned SID_W = h2fp_pkg::STREAM_W;

    // Configuration and parse state
    logic                 expect_preface_reg;
    logic [LEN_W-1:0]     max_payload_reg;
    logic                 fresh_reg;
    h2fp_pkg::phase_t     phase_reg, phase_next;
    logic [4:0]           preface_pos_reg, preface_pos_next;
    logic                 preface_failed_reg, preface_failed_next;
    logic [3:0]           header_pos_reg, header_pos_next;
    logic [LEN_W-1:0]     held_length_reg, held_length_next;
    logic [7:0]           held_type_reg, held_type_next;
    logic [7:0]           held_flags_reg, held_flags_next;
    logic [SID_W-1:0]     held_stream_reg, held_stream_next;
    logic [LEN_W-1:0]     remaining_reg, remaining_next;
    logic [7:0]           pad_count_reg, pad_count_next;

    // Event output stage
    logic                 res_valid_reg;
    h2fp_pkg::result_t    res_reg, res_next;
    logic                 res_load;

    logic                 accept;
    logic                 cfg_wr;
    logic [7:0]           b;
    logic                 pre_last;
    logic                 pre_mismatch;
    logic                 hdr_last;
    logic                 pay_last;
    logic                 too_large;
    logic                 len_zero;
    logic [LEN_W-1:0]     len_m1;
    logic [LEN_W-1:0]     pad_ext;
    logic [LEN_W-1:0]     body_calc;
    logic                 is_data;
    logic                 is_headers;
    h2fp_pkg::result_t    frame_res;

    // Handshakes
    assign byte_in.ready = !res_valid_reg || evt_out.ready;
    assign accept        = byte_in.valid && byte_in.ready;
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign b             = byte_in.data_byte;

    // Phase step conditions
    assign pre_last     = (preface_pos_reg == 5'(h2fp_pkg::PREFACE_LEN - 1));
    assign pre_mismatch = (b != h2fp_pkg::PREFACE_TEXT[preface_pos_reg]);
    assign hdr_last     = (header_pos_reg == 4'(h2fp_pkg::HEADER_LEN - 1));
    assign pay_last     = (remaining_reg <= LEN_W'(1));
    assign too_large    = (held_length_next > max_payload_reg);
    assign len_zero     = (held_length_next == '0);

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                h2fp_pkg::PH_PREFACE:
                begin
                    if (pre_last)
                        phase_next = preface_failed_next ? h2fp_pkg::PH_DEAD
                                                         : h2fp_pkg::PH_HEADER;
                end
                h2fp_pkg::PH_HEADER:
                begin
                    if (hdr_last)
                    begin
                        if (too_large)
                            phase_next = h2fp_pkg::PH_DEAD;
                        else if (!len_zero)
                            phase_next = h2fp_pkg::PH_PAYLOAD;
                    end
                end
                h2fp_pkg::PH_PAYLOAD:
                begin
                    if (pay_last)
                        phase_next = h2fp_pkg::PH_HEADER;
                end
                h2fp_pkg::PH_DEAD:
                begin
                    phase_next = h2fp_pkg::PH_DEAD;
                end
                default:
                begin
                    phase_next = h2fp_pkg::PH_DEAD;
                end
            endcase
        end
        else if (cfg_wr && paddr[2] == h2fp_pkg::REG_EXPECT_PREFACE && fresh_reg)
        begin
            phase_next = pwdata[0] ? h2fp_pkg::PH_PREFACE : h2fp_pkg::PH_HEADER;
        end
    end

    // Field capture and counters
    always_comb
    begin
        preface_pos_next    = preface_pos_reg;
        preface_failed_next = preface_failed_reg;
        header_pos_next     = header_pos_reg;
        held_length_next    = held_length_reg;
        held_type_next      = held_type_reg;
        held_flags_next     = held_flags_reg;
        held_stream_next    = held_stream_reg;
        remaining_next      = remaining_reg;
        pad_count_next      = pad_count_reg;

        unique case (phase_reg)
            h2fp_pkg::PH_PREFACE:
            begin
                preface_failed_next = preface_failed_reg | pre_mismatch;
                if (!pre_last)
                    preface_pos_next = preface_pos_reg + 5'd1;
            end
            h2fp_pkg::PH_HEADER:
            begin
                unique case (header_pos_reg)
                    4'd0: held_length_next = {b, 16'h0000};
                    4'd1: held_length_next[15:8] = b;
                    4'd2: held_length_next[7:0] = b;
                    4'd3: held_type_next = b;
                    4'd4: held_flags_next = b;
                    4'd5: held_stream_next = {b[6:0] & h2fp_pkg::STREAM_TOP_MASK, 24'h000000};
                    4'd6: held_stream_next[23:16] = b;
                    4'd7: held_stream_next[15:8] = b;
                    default: held_stream_next[7:0] = b;
                endcase
                if (hdr_last)
                begin
                    header_pos_next = '0;
                    pad_count_next  = '0;
                    remaining_next  = held_length_next;
                end
                else
                begin
                    header_pos_next = header_pos_reg + 4'd1;
                end
            end
            h2fp_pkg::PH_PAYLOAD:
            begin
                if (remaining_reg == held_length_reg)
                    pad_count_next = b;
                remaining_next = pay_last ? '0 : remaining_reg - LEN_W'(1);
            end
            h2fp_pkg::PH_DEAD:
            begin
                preface_pos_next = preface_pos_reg;
            end
            default:
            begin
                preface_pos_next = preface_pos_reg;
            end
        endcase
    end

    // Frame complete event from the captured header
    assign is_data    = (held_type_next == h2fp_pkg::TYPE_DATA);
    assign is_headers = (held_type_next == h2fp_pkg::TYPE_HEADERS);
    assign len_m1     = held_length_next - LEN_W'(1);
    assign pad_ext    = LEN_W'(pad_count_next);

    always_comb
    begin
        body_calc = held_length_next;
        if (is_data && held_flags_next[h2fp_pkg::FLAG_BIT_PADDED])
        begin
            if (len_zero)
                body_calc = '0;
            else if (pad_ext <= len_m1)
                body_calc = len_m1 - pad_ext;
            else
                body_calc = '0;
        end
    end

    always_comb
    begin
        frame_res.event_res     = h2fp_pkg::EV_FRAME_DONE;
        frame_res.frame_type    = held_type_next;
        frame_res.known_type    = (held_type_next <= h2fp_pkg::TYPE_LAST_KNOWN);
        frame_res.frame_flags   = held_flags_next;
        frame_res.stream_number = held_stream_next;
        frame_res.payload_len   = held_length_next;
        frame_res.body_len      = body_calc;
        frame_res.stream_end    = (is_data || is_headers)
                                  && held_flags_next[h2fp_pkg::FLAG_BIT_STREAM_END];
        frame_res.headers_end   = is_headers
                                  && held_flags_next[h2fp_pkg::FLAG_BIT_HEADERS_END];
    end

    // Select the event for this byte
    always_comb
    begin
        res_load = 1'b0;
        res_next = '0;
        unique case (phase_reg)
            h2fp_pkg::PH_PREFACE:
            begin
                if (pre_last)
                begin
                    res_load           = 1'b1;
                    res_next.event_res = preface_failed_next ? h2fp_pkg::EV_PREFACE_BAD
                                                             : h2fp_pkg::EV_PREFACE_OK;
                end
            end
            h2fp_pkg::PH_HEADER:
            begin
                if (hdr_last && too_large)
                begin
                    res_load             = 1'b1;
                    res_next             = frame_res;
                    res_next.event_res   = h2fp_pkg::EV_TOO_LARGE;
                    res_next.body_len    = '0;
                    res_next.stream_end  = 1'b0;
                    res_next.headers_end = 1'b0;
                end
                else if (hdr_last && len_zero)
                begin
                    res_load = 1'b1;
                    res_next = frame_res;
                end
            end
            h2fp_pkg::PH_PAYLOAD:
            begin
                if (pay_last)
                begin
                    res_load = 1'b1;
                    res_next = frame_res;
                end
            end
            h2fp_pkg::PH_DEAD:
            begin
                res_load = 1'b0;
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    // Advance parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= h2fp_pkg::PH_PREFACE;
            fresh_reg          <= 1'b1;
            preface_pos_reg    <= '0;
            preface_failed_reg <= 1'b0;
            header_pos_reg     <= '0;
            held_length_reg    <= '0;
            held_type_reg      <= '0;
            held_flags_reg     <= '0;
            held_stream_reg    <= '0;
            remaining_reg      <= '0;
            pad_count_reg      <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (accept)
            begin
                fresh_reg          <= 1'b0;
                preface_pos_reg    <= preface_pos_next;
                preface_failed_reg <= preface_failed_next;
                header_pos_reg     <= header_pos_next;
                held_length_reg    <= held_length_next;
                held_type_reg      <= held_type_next;
                held_flags_reg     <= held_flags_next;
                held_stream_reg    <= held_stream_next;
                remaining_reg      <= remaining_next;
                pad_count_reg      <= pad_count_next;
            end
        end
    end

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_preface_reg <= 1'b1;
            max_payload_reg    <= h2fp_pkg::MAX_PAYLOAD_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                h2fp_pkg::REG_EXPECT_PREFACE: expect_preface_reg <= pwdata[0];
                h2fp_pkg::REG_MAX_PAYLOAD:    max_payload_reg    <= pwdata[LEN_W-1:0];
                default:                      max_payload_reg    <= max_payload_reg;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == h2fp_pkg::REG_MAX_PAYLOAD)
                    ? {{(32-LEN_W){1'b0}}, max_payload_reg}
                    : {31'h0, expect_preface_reg};

    // Event register: load on a new event, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (accept && res_load)
            res_valid_reg <= 1'b1;
        else if (evt_out.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_load)
            res_reg <= res_next;
    end

    assign evt_out.valid         = res_valid_reg;
    assign evt_out.event_res     = res_reg.event_res;
    assign evt_out.frame_type    = res_reg.frame_type;
    assign evt_out.known_type    = res_reg.known_type;
    assign evt_out.frame_flags   = res_reg.frame_flags;
    assign evt_out.stream_number = res_reg.stream_number;
    assign evt_out.payload_len   = res_reg.payload_len;
    assign evt_out.body_len      = res_reg.body_len;
    assign evt_out.stream_end    = res_reg.stream_end;
    assign evt_out.headers_end   = res_reg.headers_end;

    // Checks
    `H2FP_ASSERT_NEXT(a_dead_sticky, phase_reg == h2fp_pkg::PH_DEAD,
        phase_reg == h2fp_pkg::PH_DEAD, "parser left the dead phase")
    `H2FP_ASSERT_SAME(a_payload_count, phase_reg == h2fp_pkg::PH_PAYLOAD,
        remaining_reg != '0, "payload phase with nothing remaining")
    `H2FP_ASSERT_SAME(a_header_pos, phase_reg == h2fp_pkg::PH_HEADER,
        header_pos_reg < 4'(h2fp_pkg::HEADER_LEN), "header position out of range")
    `H2FP_ASSERT_NEXT(a_preface_end,
        accept && phase_reg == h2fp_pkg::PH_PREFACE && pre_last,
        res_valid_reg && (phase_reg == h2fp_pkg::PH_HEADER || phase_reg == h2fp_pkg::PH_DEAD),
        "preface end without event or phase change")

endmodule
